FILE: src/ibmcr_pkg.sv
package ibmcr_pkg;

  localparam int MAX_DET = 64;
  localparam int DET_AW = $clog2(MAX_DET);
  localparam int DET_CW = $clog2(MAX_DET + 1);

  localparam int CACHE_N = 64;
  localparam int CACHE_AW = $clog2(CACHE_N);
  localparam int CACHE_CW = $clog2(CACHE_N + 1);

  // Field widths are fixed by the item format.
  localparam int COORD_W = 20;
  localparam int CLS_W = 8;
  localparam int KEY_W = 32;
  localparam int OP_W = 2;
  localparam int SRC_W = 2;

  // A positive overlap span never exceeds a positive size, so it fits in
  // COORD_W-1 bits. Areas are products of two such spans.
  localparam int SPAN_W = COORD_W - 1;
  localparam int AREA_W = 2 * SPAN_W;
  localparam int UNI_W = AREA_W + 1;
  localparam int HALF_W = (UNI_W + 1) / 2;
  localparam int PROD_W = 4 * HALF_W;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_PRUNE = 2'd2;

  localparam logic [SRC_W-1:0] SRC_DET = 2'd0;
  localparam logic [SRC_W-1:0] SRC_CACHE = 2'd1;
  localparam logic [SRC_W-1:0] SRC_FALLBACK = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] width;
    logic signed [COORD_W-1:0] height;
  } box_t;

  typedef struct packed {
    box_t box;
    logic [CLS_W-1:0] cls;
  } det_rec_t;

  typedef struct packed {
    logic en;
    logic first;
    det_rec_t rec;
  } det_wr_t;

  typedef struct packed {
    logic clear;
    logic start;
  } iou_ctl_t;

  typedef struct packed {
    logic en;
    logic new_key;
    logic [CACHE_AW-1:0] addr;
    logic [KEY_W-1:0] key;
    logic [CLS_W-1:0] cls;
  } cache_wr_t;

endpackage

FILE: src/ibmcr_det_store.sv
module ibmcr_det_store (
  input  logic                     clk,
  input  logic                     rst,
  input  ibmcr_pkg::det_wr_t       wr,
  input  logic                     rd_en,
  input  logic [ibmcr_pkg::DET_AW-1:0] rd_addr,
  output ibmcr_pkg::det_rec_t      rd_data,
  output logic [ibmcr_pkg::DET_CW-1:0] count
);
  import ibmcr_pkg::*;

  det_rec_t mem [MAX_DET];
  logic [DET_CW-1:0] base;
  logic room;

  // A first-of-frame load restarts the store at entry zero.
  always_comb begin
    base = wr.first ? '0 : count;
    room = base < DET_CW'(MAX_DET);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (wr.en && room) begin
      count <= base + DET_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && room) begin
      mem[base[DET_AW-1:0]] <= wr.rec;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/ibmcr_cache.sv
module ibmcr_cache (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [ibmcr_pkg::CACHE_AW-1:0] rd_addr,
  output logic [ibmcr_pkg::KEY_W-1:0]  rd_key,
  output logic [ibmcr_pkg::CLS_W-1:0]  rd_cls,
  output logic [ibmcr_pkg::CACHE_N-1:0] valid,
  input  ibmcr_pkg::cache_wr_t         wr,
  input  logic                         prune
);
  import ibmcr_pkg::*;

  logic [KEY_W-1:0] key_mem [CACHE_N];
  logic [CLS_W-1:0] cls_mem [CACHE_N];
  logic [CACHE_N-1:0] active;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      active <= '0;
    end else if (prune) begin
      valid <= valid & active;
      active <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
      active[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.new_key) begin
      key_mem[wr.addr] <= wr.key;
    end
    if (wr.en) begin
      cls_mem[wr.addr] <= wr.cls;
    end
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_cls <= cls_mem[rd_addr];
    end
  end

endmodule

FILE: src/ibmcr_iou.sv
module ibmcr_iou (
  input  logic                        clk,
  input  logic                        rst,
  input  ibmcr_pkg::iou_ctl_t         ctl,
  input  ibmcr_pkg::box_t             qbox,
  input  ibmcr_pkg::box_t             dbox,
  input  logic [ibmcr_pkg::CLS_W-1:0] dcls,
  output logic                        done,
  output logic                        found,
  output logic [ibmcr_pkg::CLS_W-1:0] best_cls
);
  import ibmcr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SPAN = 3'd1;
  localparam logic [2:0] ST_MUL = 3'd2;
  localparam logic [2:0] ST_UNI = 3'd3;
  localparam logic [2:0] ST_PP = 3'd4;
  localparam logic [2:0] ST_CMP = 3'd5;

  localparam int EXT_W = COORD_W + 1;

  logic [2:0] state;
  logic [1:0] k;
  logic [SPAN_W-1:0] iw, ih, dwp, dhp;
  logic [AREA_W-1:0] qa, inter, da, best_i;
  logic [UNI_W-1:0] uni, best_u;
  logic [PROD_W-1:0] acc_a, acc_b;

  logic [SPAN_W-1:0] iw_c, ih_c, qw_c, qh_c;
  logic [2*HALF_W-1:0] i_x, bu_x, bi_x, u_x;
  logic [HALF_W-1:0] a_h, b_h, c_h, d_h;
  logic [2*HALF_W-1:0] pa, pb;
  logic [PROD_W-1:0] ta, tb;
  logic [1:0] sh;

  function automatic logic [SPAN_W-1:0] pos(input logic signed [COORD_W-1:0] v);
    return v[COORD_W-1] ? '0 : v[SPAN_W-1:0];
  endfunction

  function automatic logic [SPAN_W-1:0] span(input logic signed [COORD_W-1:0] a0,
                                              input logic signed [COORD_W-1:0] as,
                                              input logic signed [COORD_W-1:0] b0,
                                              input logic signed [COORD_W-1:0] bs);
    logic signed [EXT_W-1:0] ae, be, lo, hi, d;
    ae = EXT_W'(a0) + EXT_W'(as);
    be = EXT_W'(b0) + EXT_W'(bs);
    lo = (a0 > b0) ? EXT_W'(a0) : EXT_W'(b0);
    hi = (ae < be) ? ae : be;
    d = hi - lo;
    return (hi > lo) ? d[SPAN_W-1:0] : '0;
  endfunction

  always_comb begin
    iw_c = span(qbox.left, qbox.width, dbox.left, dbox.width);
    ih_c = span(qbox.top, qbox.height, dbox.top, dbox.height);
    qw_c = pos(qbox.width);
    qh_c = pos(qbox.height);

    // Partial products of inter*best_u and best_i*uni, one half pair a cycle.
    i_x = (2*HALF_W)'(inter);
    bu_x = (2*HALF_W)'(best_u);
    bi_x = (2*HALF_W)'(best_i);
    u_x = (2*HALF_W)'(uni);
    a_h = k[0] ? i_x[2*HALF_W-1:HALF_W] : i_x[HALF_W-1:0];
    b_h = k[1] ? bu_x[2*HALF_W-1:HALF_W] : bu_x[HALF_W-1:0];
    c_h = k[0] ? bi_x[2*HALF_W-1:HALF_W] : bi_x[HALF_W-1:0];
    d_h = k[1] ? u_x[2*HALF_W-1:HALF_W] : u_x[HALF_W-1:0];
    pa = a_h * b_h;
    pb = c_h * d_h;
    sh = {1'b0, k[0]} + {1'b0, k[1]};
    case (sh)
      2'd0: begin
        ta = PROD_W'(pa);
        tb = PROD_W'(pb);
      end
      2'd1: begin
        ta = PROD_W'(pa) << HALF_W;
        tb = PROD_W'(pb) << HALF_W;
      end
      default: begin
        ta = PROD_W'(pa) << (2 * HALF_W);
        tb = PROD_W'(pb) << (2 * HALF_W);
      end
    endcase
  end

  assign done = (state == ST_CMP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      found <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctl.clear) begin
            found <= 1'b0;
          end else if (ctl.start) begin
            state <= ST_SPAN;
          end
        end
        ST_SPAN: state <= ST_MUL;
        ST_MUL: state <= ST_UNI;
        ST_UNI: state <= ST_PP;
        ST_PP: begin
          if (k == 2'd3) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_IDLE;
          if (acc_a > acc_b) begin
            found <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (ctl.clear) begin
          qa <= qw_c * qh_c;
          best_i <= '0;
          best_u <= UNI_W'(1);
        end
      end
      ST_SPAN: begin
        iw <= iw_c;
        ih <= ih_c;
        dwp <= pos(dbox.width);
        dhp <= pos(dbox.height);
      end
      ST_MUL: begin
        inter <= iw * ih;
        da <= dwp * dhp;
      end
      ST_UNI: begin
        uni <= UNI_W'(qa) + UNI_W'(da) - UNI_W'(inter);
        acc_a <= '0;
        acc_b <= '0;
        k <= 2'd0;
      end
      ST_PP: begin
        acc_a <= acc_a + ta;
        acc_b <= acc_b + tb;
        k <= k + 2'd1;
      end
      ST_CMP: begin
        if (acc_a > acc_b) begin
          best_i <= inter;
          best_u <= uni;
          best_cls <= dcls;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/iou_best_match_class_resolver.sv
// A load, prune or unused request leaves the block idle and gives no result.
// A query raises out_valid once each stored detection and every cache entry is checked
// (CACHE_N = 64): each detection costs one memory read, one wait and an IoU compare,
// then the cache keys are read one per cycle and the matching class is fetched.
// Requests stall until the result is registered; a stalled earlier result delays that.
// Synchronous active-high rst empties the detection store and cache, sets fallback to 0.
module iou_best_match_class_resolver (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ibmcr_pkg::OP_W-1:0]          op,
  input  logic                                first_of_frame,
  input  logic signed [ibmcr_pkg::COORD_W-1:0] box_left,
  input  logic signed [ibmcr_pkg::COORD_W-1:0] box_top,
  input  logic signed [ibmcr_pkg::COORD_W-1:0] box_width,
  input  logic signed [ibmcr_pkg::COORD_W-1:0] box_height,
  input  logic [ibmcr_pkg::CLS_W-1:0]         det_class,
  input  logic [ibmcr_pkg::KEY_W-1:0]         track_key,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ibmcr_pkg::CLS_W-1:0]         resolved_class,
  output logic [ibmcr_pkg::SRC_W-1:0]         class_source,
  output logic                                cache_full,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ibmcr_pkg::CLS_W-1:0]         cfg_data
);
  import ibmcr_pkg::*;

  // Query sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_QINIT = 3'd1;
  localparam logic [2:0] ST_DREAD = 3'd2;
  localparam logic [2:0] ST_DWAIT = 3'd3;
  localparam logic [2:0] ST_DCALC = 3'd4;
  localparam logic [2:0] ST_CSCAN = 3'd5;
  localparam logic [2:0] ST_CCLS = 3'd6;
  localparam logic [2:0] ST_CRES = 3'd7;

  logic [2:0] state;
  logic [CLS_W-1:0] fallback;
  box_t qbox;
  logic [KEY_W-1:0] qkey;
  logic [DET_CW-1:0] didx;
  logic [CACHE_CW-1:0] cidx;
  logic pv;
  logic [CACHE_AW-1:0] pidx;
  logic [CACHE_AW-1:0] slot, free;
  logic slot_found, free_found;

  logic accept;
  det_wr_t det_wr;
  logic det_rd_en;
  det_rec_t det_rd;
  logic [DET_CW-1:0] det_count;

  iou_ctl_t iou_ctl;
  logic iou_done, iou_found;
  logic [CLS_W-1:0] iou_cls;

  logic c_rd_en;
  logic [CACHE_AW-1:0] c_rd_addr;
  logic [KEY_W-1:0] c_key;
  logic [CLS_W-1:0] c_cls;
  logic [CACHE_N-1:0] c_valid;
  cache_wr_t c_wr;
  logic c_prune;
  logic out_free;

  // New requests are taken only between queries; a finished result may still
  // be waiting in the output register.
  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    det_wr.en = accept && (op == OP_LOAD);
    det_wr.first = first_of_frame;
    det_wr.rec.box.left = box_left;
    det_wr.rec.box.top = box_top;
    det_wr.rec.box.width = box_width;
    det_wr.rec.box.height = box_height;
    det_wr.rec.cls = det_class;

    det_rd_en = (state == ST_DREAD) && (didx != det_count);

    iou_ctl.clear = (state == ST_QINIT);
    iou_ctl.start = (state == ST_DWAIT);

    c_prune = accept && (op == OP_PRUNE);

    // The cache read port walks the keys during the scan and then fetches the
    // class of the matching entry.
    c_rd_en = 1'b0;
    c_rd_addr = cidx[CACHE_AW-1:0];
    if (state == ST_CSCAN) begin
      c_rd_en = (cidx < CACHE_CW'(CACHE_N));
    end else if (state == ST_CCLS) begin
      c_rd_en = slot_found;
      c_rd_addr = slot;
    end

    c_wr.en = (state == ST_CRES) && out_free && (slot_found || free_found);
    c_wr.new_key = !slot_found;
    c_wr.addr = slot_found ? slot : free;
    c_wr.key = qkey;
    if (iou_found) begin
      c_wr.cls = iou_cls;
    end else if (slot_found) begin
      c_wr.cls = c_cls;
    end else begin
      c_wr.cls = fallback;
    end
  end

  ibmcr_det_store u_det (
    .clk     (clk),
    .rst     (rst),
    .wr      (det_wr),
    .rd_en   (det_rd_en),
    .rd_addr (didx[DET_AW-1:0]),
    .rd_data (det_rd),
    .count   (det_count)
  );

  ibmcr_iou u_iou (
    .clk      (clk),
    .rst      (rst),
    .ctl      (iou_ctl),
    .qbox     (qbox),
    .dbox     (det_rd.box),
    .dcls     (det_rd.cls),
    .done     (iou_done),
    .found    (iou_found),
    .best_cls (iou_cls)
  );

  ibmcr_cache u_cache (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (c_rd_en),
    .rd_addr (c_rd_addr),
    .rd_key  (c_key),
    .rd_cls  (c_cls),
    .valid   (c_valid),
    .wr      (c_wr),
    .prune   (c_prune)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fallback <= '0;
    end else if (cfg_valid && cfg_ready) begin
      fallback <= cfg_data;
    end
  end

  // Query sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      pv <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (op == OP_QUERY)) begin
            state <= ST_QINIT;
          end
        end
        ST_QINIT: state <= ST_DREAD;
        ST_DREAD: begin
          if (didx == det_count) begin
            state <= ST_CSCAN;
          end else begin
            state <= ST_DWAIT;
          end
        end
        ST_DWAIT: state <= ST_DCALC;
        ST_DCALC: begin
          if (iou_done) begin
            state <= ST_DREAD;
          end
        end
        ST_CSCAN: begin
          pv <= c_rd_en;
          if (pv && (pidx == CACHE_AW'(CACHE_N - 1))) begin
            state <= ST_CCLS;
          end
        end
        ST_CCLS: begin
          pv <= 1'b0;
          state <= ST_CRES;
        end
        ST_CRES: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Query datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept && (op == OP_QUERY)) begin
          qbox.left <= box_left;
          qbox.top <= box_top;
          qbox.width <= box_width;
          qbox.height <= box_height;
          qkey <= track_key;
        end
        didx <= '0;
      end
      ST_DREAD: begin
        cidx <= '0;
        slot_found <= 1'b0;
        free_found <= 1'b0;
      end
      ST_DCALC: begin
        if (iou_done) begin
          didx <= didx + DET_CW'(1);
        end
      end
      ST_CSCAN: begin
        if (c_rd_en) begin
          cidx <= cidx + CACHE_CW'(1);
        end
        pidx <= cidx[CACHE_AW-1:0];
        // The first valid entry holding the key wins, and the first empty
        // entry is kept for a new key.
        if (pv) begin
          if (c_valid[pidx]) begin
            if (!slot_found && (c_key == qkey)) begin
              slot_found <= 1'b1;
              slot <= pidx;
            end
          end else if (!free_found) begin
            free_found <= 1'b1;
            free <= pidx;
          end
        end
      end
      ST_CRES: begin
        if (out_free) begin
          resolved_class <= c_wr.cls;
          if (iou_found) begin
            class_source <= SRC_DET;
          end else if (slot_found) begin
            class_source <= SRC_CACHE;
          end else begin
            class_source <= SRC_FALLBACK;
          end
          cache_full <= !slot_found && !free_found;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/ibmcr_checker.sv
module ibmcr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [ibmcr_pkg::OP_W-1:0]          op,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [ibmcr_pkg::CLS_W-1:0]         resolved_class,
  input logic [ibmcr_pkg::SRC_W-1:0]         class_source,
  input logic                                cache_full
);
  import ibmcr_pkg::*;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(resolved_class)
      && $stable(class_source) && $stable(cache_full))
    else $error("result changed while stalled");

  // A cached class means the key was found, so the cache cannot be full.
  a_full_src: assert property (@(posedge clk) disable iff (rst)
    out_valid && cache_full |-> class_source != SRC_CACHE)
    else $error("cache_full with cached class");

  // A query needs the whole scan, so no result follows in the next cycle.
  a_no_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_QUERY |=> !$rose(out_valid))
    else $error("result too early after query");

  // Reset leaves no result pending.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind iou_best_match_class_resolver ibmcr_checker u_chk (.*);

FILE: sim/iou_best_match_class_resolver_tb.sv
module iou_best_match_class_resolver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ibmcr_pkg::*;

  // A request waiting to be driven. When hold_drain is set, the driver keeps
  // the request back until every expected result has come out of the block.
  typedef struct {
    logic [OP_W-1:0] op;
    logic first;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] width;
    logic signed [COORD_W-1:0] height;
    logic [CLS_W-1:0] cls;
    logic [KEY_W-1:0] key;
    logic hold_drain;
  } req_t;

  typedef struct {
    logic [CLS_W-1:0] cls;
    logic [SRC_W-1:0] src;
    logic full;
  } class_result_t;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES = 800;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] op = OP_LOAD;
  logic first_of_frame = 1'b0;
  logic signed [COORD_W-1:0] box_left = '0;
  logic signed [COORD_W-1:0] box_top = '0;
  logic signed [COORD_W-1:0] box_width = '0;
  logic signed [COORD_W-1:0] box_height = '0;
  logic [CLS_W-1:0] det_class = '0;
  logic [KEY_W-1:0] track_key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CLS_W-1:0] resolved_class;
  logic [SRC_W-1:0] class_source;
  logic cache_full;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CLS_W-1:0] cfg_data = '0;

  iou_best_match_class_resolver dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .first_of_frame(first_of_frame),
    .box_left(box_left), .box_top(box_top),
    .box_width(box_width), .box_height(box_height),
    .det_class(det_class), .track_key(track_key),
    .out_valid(out_valid), .out_stall(out_stall),
    .resolved_class(resolved_class), .class_source(class_source),
    .cache_full(cache_full),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  req_t pending_reqs[$];
  req_t next_req;
  class_result_t expected_classes[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  logic in_fire = 1'b0;

  // Predictor state: the detection store, the per-track class cache and the
  // one configuration register, all as the block holds them.
  longint det_left[MAX_DET];
  longint det_top[MAX_DET];
  longint det_width[MAX_DET];
  longint det_height[MAX_DET];
  logic [CLS_W-1:0] det_cls[MAX_DET];
  int det_total = 0;
  logic [KEY_W-1:0] track_keys[CACHE_N];
  logic [CLS_W-1:0] track_cls[CACHE_N];
  bit track_valid[CACHE_N];
  bit track_active[CACHE_N];
  logic [CLS_W-1:0] fallback = '0;

  // Appends one request at the tail of the pending queue.
  task automatic add_req(input req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic longint overlap(input longint a0, input longint a1,
                                     input longint b0, input longint b1);
    longint lo;
    longint hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic longint box_area(input longint w, input longint h);
    return ((w > 0) ? w : 0) * ((h > 0) ? h : 0);
  endfunction

  // Applies one accepted request to the predictor state. Loads and prunes change
  // state only, unused codes nothing; a query also queues its expected class.
  task automatic resolve_request(input logic [OP_W-1:0] code, input logic first,
                                 input longint x, input longint y,
                                 input longint w, input longint h,
                                 input logic [CLS_W-1:0] cls,
                                 input logic [KEY_W-1:0] key);
    class_result_t res;
    logic [127:0] best_inter;
    logic [127:0] best_union;
    longint iw;
    longint ih;
    longint inter;
    longint uni;
    longint qa;
    bit found;
    int slot;
    int free_slot;
    if (code == OP_LOAD) begin
      if (first) det_total = 0;
      if (det_total < MAX_DET) begin
        det_left[det_total] = x;
        det_top[det_total] = y;
        det_width[det_total] = w;
        det_height[det_total] = h;
        det_cls[det_total] = cls;
        det_total++;
      end
    end else if (code == OP_PRUNE) begin
      for (int i = 0; i < CACHE_N; i++) begin
        track_valid[i] = track_valid[i] && track_active[i];
        track_active[i] = 1'b0;
      end
    end else if (code == OP_QUERY) begin
      best_inter = 0;
      best_union = 1;
      found = 1'b0;
      res.cls = '0;
      res.full = 1'b0;
      qa = box_area(w, h);
      // Scan the detections in load order; only a strictly larger IoU
      // replaces the current best, so the earliest one wins a tie.
      for (int i = 0; i < det_total; i++) begin
        iw = overlap(x, x + w, det_left[i], det_left[i] + det_width[i]);
        ih = overlap(y, y + h, det_top[i], det_top[i] + det_height[i]);
        inter = iw * ih;
        uni = qa + box_area(det_width[i], det_height[i]) - inter;
        if (uni > 0 && inter > 0 &&
            128'(inter) * best_union > best_inter * 128'(uni)) begin
          best_inter = 128'(inter);
          best_union = 128'(uni);
          res.cls = det_cls[i];
          found = 1'b1;
        end
      end
      slot = CACHE_N;
      free_slot = CACHE_N;
      for (int i = 0; i < CACHE_N; i++) begin
        if (track_valid[i]) begin
          if (slot == CACHE_N && track_keys[i] == key) slot = i;
        end else if (free_slot == CACHE_N) begin
          free_slot = i;
        end
      end
      if (found) begin
        res.src = SRC_DET;
      end else if (slot < CACHE_N) begin
        res.cls = track_cls[slot];
        res.src = SRC_CACHE;
      end else begin
        res.cls = fallback;
        res.src = SRC_FALLBACK;
      end
      // A new key takes the first free entry; with none free the result
      // still comes out, flagged, and nothing is stored.
      if (slot == CACHE_N) begin
        if (free_slot < CACHE_N) begin
          slot = free_slot;
          track_valid[slot] = 1'b1;
          track_keys[slot] = key;
        end else begin
          res.full = 1'b1;
        end
      end
      if (slot < CACHE_N) begin
        track_cls[slot] = res.cls;
        track_active[slot] = 1'b1;
      end
      expected_classes = {expected_classes, res};
    end
  endtask

  // Driver: a new request goes out at the falling edge once the previous
  // one has been taken, unless the sender idles or hold_drain holds it back.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_reqs.size() > 0 &&
          !(pending_reqs[0].hold_drain && expected_classes.size() > 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        op <= next_req.op;
        first_of_frame <= next_req.first;
        box_left <= next_req.left;
        box_top <= next_req.top;
        box_width <= next_req.width;
        box_height <= next_req.height;
        det_class <= next_req.cls;
        track_key <= next_req.key;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: everything is sampled at the rising edge. Requests are fed to
  // the predictor before results are checked, so a result can never be
  // compared ahead of its own request.
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) fallback = cfg_data;
      if (in_valid && !in_stall)
        resolve_request(op, first_of_frame, longint'(box_left), longint'(box_top),
                        longint'(box_width), longint'(box_height),
                        det_class, track_key);
      if (out_valid && !out_stall) begin
        if (expected_classes.size() == 0) begin
          report_mismatch($sformatf("unexpected result class %0d", resolved_class));
        end else begin
          if (resolved_class !== expected_classes[0].cls)
            report_mismatch($sformatf("resolved_class %0d, want %0d",
                                      resolved_class, expected_classes[0].cls));
          if (class_source !== expected_classes[0].src)
            report_mismatch($sformatf("class_source %0d, want %0d",
                                      class_source, expected_classes[0].src));
          if (cache_full !== expected_classes[0].full)
            report_mismatch($sformatf("cache_full %0b, want %0b",
                                      cache_full, expected_classes[0].full));
          void'(expected_classes.pop_front());
        end
      end
      // The watchdog restarts on any accepted request, result or write.
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic req_t make_req(input logic [OP_W-1:0] code, input logic first,
                                    input int x, input int y, input int w, input int h,
                                    input int cls, input logic [KEY_W-1:0] key);
    req_t r;
    r.op = code;
    r.first = first;
    r.left = x[COORD_W-1:0];
    r.top = y[COORD_W-1:0];
    r.width = w[COORD_W-1:0];
    r.height = h[COORD_W-1:0];
    r.cls = cls[CLS_W-1:0];
    r.key = key;
    r.hold_drain = 1'b0;
    return r;
  endfunction

  // Boxes are mostly small and clustered so that queries overlap several
  // detections; now and then a size is zero or negative.
  function automatic req_t clustered_req(input logic [OP_W-1:0] code,
                                         input logic first, input logic [KEY_W-1:0] key);
    int w;
    int h;
    w = $urandom_range(400, 1);
    h = $urandom_range(400, 1);
    if ($urandom_range(19) == 0) w = -int'($urandom_range(50));
    if ($urandom_range(19) == 0) h = -int'($urandom_range(50));
    return make_req(code, first, int'($urandom_range(600)) - 300,
                    int'($urandom_range(600)) - 300, w, h, $urandom_range(255), key);
  endfunction

  // Any bit pattern in every field, including the unused operation code.
  function automatic req_t noise_req();
    req_t r;
    r.op = OP_W'($urandom_range(3));
    r.first = 1'($urandom_range(1));
    r.left = COORD_W'($urandom);
    r.top = COORD_W'($urandom);
    r.width = COORD_W'($urandom);
    r.height = COORD_W'($urandom);
    r.cls = CLS_W'($urandom);
    r.key = $urandom;
    r.hold_drain = 1'b0;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(11);
  endfunction

  task automatic queue_frames(input int count);
    req_t r;
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) == 0) begin
        r = noise_req();
        r.hold_drain = ($urandom_range(19) == 0);
        add_req(r);
        n++;
      end else begin
        add_req(clustered_req(OP_LOAD, 1'b1, '0));
        repeat ($urandom_range(8)) add_req(clustered_req(OP_LOAD, 1'b0, '0));
        repeat ($urandom_range(5, 1)) begin
          r = clustered_req(OP_QUERY, 1'b0, pick_key());
          r.hold_drain = ($urandom_range(19) == 0);
          add_req(r);
        end
        if ($urandom_range(4) != 0)
          add_req(make_req(OP_PRUNE, 1'b0, 0, 0, 0, 0, 0, '0));
        n = pending_reqs.size();
      end
    end
  endtask

  // Lets the queue run dry and every result arrive, then settles so that any
  // trailing load or prune has been applied.
  task automatic drain_requests();
    while (pending_reqs.size() > 0 || in_valid || expected_classes.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fallback(input logic [CLS_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  localparam int CMIN = -524288;
  localparam int CMAX = 524287;

  initial begin
    req_t r;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_fallback(8'hFF);

    // Directed part: extreme boxes, an exact tie, every operation, the
    // unused code, a cached lookup and a lookup after the prune.
    add_req(make_req(OP_LOAD, 1'b1, CMIN, CMIN, CMAX, CMAX, 255, '0));
    add_req(make_req(OP_LOAD, 1'b0, CMAX, CMAX, CMIN, CMIN, 0, '0));
    add_req(make_req(OP_LOAD, 1'b0, 0, 0, 160, 160, 17, '0));
    add_req(make_req(OP_LOAD, 1'b0, 0, 0, 160, 160, 42, '0));
    add_req(make_req(OP_LOAD, 1'b0, 5000, 5000, 0, 80, 99, '0));
    add_req(make_req(OP_QUERY, 1'b0, CMIN, CMIN, CMAX, CMAX, 0, '0));
    add_req(make_req(OP_QUERY, 1'b0, 0, 0, 160, 160, 0, 32'd7));
    add_req(make_req(OP_QUERY, 1'b0, 9000, 9000, 10, 10, 0, 32'hFFFFFFFF));
    add_req(make_req(OP_QUERY, 1'b0, 9000, 9000, 10, 10, 0, 32'd7));
    add_req(make_req(OP_QUERY, 1'b0, 5000, 5000, 0, 0, 0, '0));
    add_req(make_req(OP_QUERY, 1'b0, 0, 0, CMIN, CMIN, 0, 32'd3));
    add_req(make_req(OP_QUERY, 1'b0, CMAX, CMAX, CMAX, CMAX, 0, 32'd4));
    add_req(make_req(OP_UNUSED, 1'b1, CMAX, CMIN, CMAX, CMIN, 255, 32'hFFFFFFFF));
    add_req(make_req(OP_PRUNE, 1'b0, 0, 0, 0, 0, 0, '0));
    add_req(make_req(OP_QUERY, 1'b0, 9000, 9000, 10, 10, 0, 32'd7));
    add_req(make_req(OP_PRUNE, 1'b0, 0, 0, 0, 0, 0, '0));
    add_req(make_req(OP_PRUNE, 1'b0, 0, 0, 0, 0, 0, '0));
    r = make_req(OP_QUERY, 1'b0, 9000, 9000, 10, 10, 0, 32'hFFFFFFFF);
    r.hold_drain = 1'b1;
    add_req(r);
    drain_requests();
    write_fallback(8'h00);

    // Fill the detection store past its end, then query against all of it.
    add_req(clustered_req(OP_LOAD, 1'b1, '0));
    repeat (MAX_DET + 2) add_req(clustered_req(OP_LOAD, 1'b0, '0));
    add_req(clustered_req(OP_QUERY, 1'b0, 32'd5));

    // Overflow the cache with fresh keys against an empty-area detection,
    // then prune twice so every entry is freed again.
    add_req(make_req(OP_LOAD, 1'b1, 0, 0, -1, 10, 1, '0));
    for (int i = 0; i < CACHE_N + 6; i++)
      add_req(make_req(OP_QUERY, 1'b0, 0, 0, 10, 10, 0, 32'h1000 + i));
    add_req(make_req(OP_QUERY, 1'b0, 0, 0, 10, 10, 0, 32'h1000));
    add_req(make_req(OP_PRUNE, 1'b0, 0, 0, 0, 0, 0, '0));
    add_req(make_req(OP_PRUNE, 1'b0, 0, 0, 0, 0, 0, '0));
    drain_requests();

    // Random part in three phases with different idle and stall rates, with the
    // fallback class changed between them while the block is idle.
    write_fallback(CLS_W'($urandom_range(254, 1)));
    send_idle_pct = 34;
    recv_stall_pct = 76;
    queue_frames(130);
    drain_requests();
    write_fallback(8'hFF);
    send_idle_pct = 76;
    recv_stall_pct = 34;
    queue_frames(130);
    drain_requests();
    write_fallback(8'h00);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_frames(130);
    drain_requests();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_classes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: iou_best_match_class_resolver.f
src/ibmcr_pkg.sv
src/ibmcr_det_store.sv
src/ibmcr_cache.sv
src/ibmcr_iou.sv
src/iou_best_match_class_resolver.sv
src/ibmcr_checker.sv
sim/iou_best_match_class_resolver_tb.sv
